FILE: rtl/utf8_sequence_packer_unit_defines.svh
// Assertion helpers for the packer top module
`ifndef UTF8_SEQUENCE_PACKER_UNIT_DEFINES_SVH
`define UTF8_SEQUENCE_PACKER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define USP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define USP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/usp_pkg.sv
package usp_pkg;

	// Byte pattern masks and values
	localparam logic [7:0] ASCII_MASK = 8'h80;
	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_PAT   = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_PAT  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_PAT  = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_PAT  = 8'hF0;

	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_ONE  = 3'd1;
	localparam logic [2:0] LEN_TWO  = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR = 3'd4;

	// One result request
	typedef struct packed {
		logic [31:0] char_word;
		logic [2:0]  char_bytes;
		logic        has_char;
		logic        format_error;
		logic        string_done;
	} result_t;

	// Sequence length from a multi-byte lead; none for anything else
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] len;
		len = LEN_NONE;
		if ((b & LEAD2_MASK) == LEAD2_PAT) begin
			len = LEN_TWO;
		end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
			len = LEN_THREE;
		end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
			len = LEN_FOUR;
		end
		return len;
	endfunction

endpackage

FILE: rtl/usp_if.sv
// Byte request channel
interface usp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_string;

	modport source (output valid, output data_byte, output end_of_string, input ready);
	modport sink (input valid, input data_byte, input end_of_string, output ready);
endinterface

// Result request channel
interface usp_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] char_word;
	logic [2:0]  char_bytes;
	logic        has_char;
	logic        format_error;
	logic        string_done;

	modport source (output valid, output char_word, output char_bytes, output has_char,
		output format_error, output string_done, input ready);
	modport sink (input valid, input char_word, input char_bytes, input has_char,
		input format_error, input string_done, output ready);
endinterface

FILE: rtl/utf8_sequence_packer_unit.sv
// UTF-8 structural checker and packer. Bytes of a string arrive on in_ch, one per request,
// with end_of_string on the last; a completed sequence of one to four bytes leaves on out_ch
// as a 32-bit word with its first byte in bits 7:0, and a malformed string gives an error
// result, then swallows bytes up to its final byte; a later final byte closes it with a second
// error result. The unit takes one byte every cycle while input ready is high: each byte is
// decoded combinationally against the open sequence and its result, if any, is written to
// an output register. A skid entry behind the output register takes one result while the
// output stalls, so input ready drops only while both entries hold results.
`include "utf8_sequence_packer_unit_defines.svh"

module utf8_sequence_packer_unit (
	input  logic     clk,
	input  logic     arst_n,
	usp_in_if.sink   in_ch,
	usp_out_if.source out_ch
);
	import usp_pkg::*;

	logic    accept;
	logic    push;
	logic    ready;
	result_t res;

	assign in_ch.ready = ready;
	assign accept      = in_ch.valid & ready;

	// Decode and collect sequence bytes
	usp_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (in_ch.data_byte),
		.end_of_string (in_ch.end_of_string),
		.push          (push),
		.res           (res)
	);

	// Hold results for the output side
	usp_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.res    (res),
		.ready  (ready),
		.out_ch (out_ch)
	);

	// A final byte always closes with a result
	`USP_ASSERT_NEXT(a_final_gives_result, clk, arst_n, accept && in_ch.end_of_string, out_ch.valid, "final byte gave no result")

	// A character result carries no error and a nonzero length
	`USP_ASSERT_IMP(a_char_clean, clk, arst_n, out_ch.valid && out_ch.has_char, !out_ch.format_error && out_ch.char_bytes != 3'd0, "character result malformed")

	// A result without a character carries an empty word
	`USP_ASSERT_IMP(a_empty_zero, clk, arst_n, out_ch.valid && !out_ch.has_char, out_ch.char_word == 32'd0 && out_ch.char_bytes == 3'd0, "empty result not zero")

endmodule

FILE: rtl/usp_core.sv
module usp_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       data_byte,
	input  logic             end_of_string,
	output logic             push,
	output usp_pkg::result_t res
);
	import usp_pkg::*;

	logic [23:0] partial_q;
	logic [2:0]  expected_q;
	logic [2:0]  seen_q;
	logic        swallow_q;
	logic        error_q;

	logic [23:0] partial_d;
	logic [2:0]  expected_d;
	logic [2:0]  seen_d;
	logic        swallow_d;
	logic        error_d;

	logic        emit;
	logic        do_fail;
	logic [2:0]  len;
	logic [2:0]  seen_inc;
	logic [31:0] lane_word;
	logic [31:0] merged;

	assign len      = lead_len(data_byte);
	assign seen_inc = seen_q + 3'd1;

	// Place a continuation byte in the lane after those already collected
	always_comb begin
		case (seen_q)
			3'd1:    lane_word = {16'd0, data_byte, 8'd0};
			3'd2:    lane_word = {8'd0, data_byte, 16'd0};
			3'd3:    lane_word = {data_byte, 24'd0};
			default: lane_word = '0;
		endcase
	end

	assign merged = {8'd0, partial_q} | lane_word;

	// Decode one byte against the open sequence
	always_comb begin
		partial_d  = partial_q;
		expected_d = expected_q;
		seen_d     = seen_q;
		swallow_d  = swallow_q;
		error_d    = error_q;
		emit       = 1'b0;
		do_fail    = 1'b0;
		res        = '0;

		if (swallow_q) begin
			if (end_of_string) begin
				emit             = 1'b1;
				res.format_error = error_q;
				res.string_done  = 1'b1;
			end
		end else if (expected_q == LEN_NONE) begin
			if (data_byte == 8'd0) begin
				if (end_of_string) begin
					emit            = 1'b1;
					res.string_done = 1'b1;
				end else begin
					swallow_d = 1'b1;
				end
			end else if ((data_byte & ASCII_MASK) == 8'd0) begin
				emit            = 1'b1;
				res.char_word   = {24'd0, data_byte};
				res.char_bytes  = LEN_ONE;
				res.has_char    = 1'b1;
				res.string_done = end_of_string;
			end else if (len == LEN_NONE || end_of_string) begin
				do_fail = 1'b1;
			end else begin
				partial_d  = {16'd0, data_byte};
				expected_d = len;
				seen_d     = LEN_ONE;
			end
		end else if ((data_byte & CONT_MASK) != CONT_PAT || seen_q == 3'd0 ||
				seen_q > LEN_THREE) begin
			do_fail = 1'b1;
		end else if (seen_inc >= expected_q) begin
			emit            = 1'b1;
			res.char_word   = merged;
			res.char_bytes  = seen_inc;
			res.has_char    = 1'b1;
			res.string_done = end_of_string;
			partial_d       = '0;
			expected_d      = LEN_NONE;
			seen_d          = 3'd0;
		end else if (end_of_string) begin
			do_fail = 1'b1;
		end else begin
			partial_d = merged[23:0];
			seen_d    = seen_inc;
		end

		// Abort the string on a malformed byte
		if (do_fail) begin
			emit             = 1'b1;
			res              = '0;
			res.format_error = 1'b1;
			res.string_done  = end_of_string;
			partial_d        = '0;
			expected_d       = LEN_NONE;
			seen_d           = 3'd0;
			swallow_d        = 1'b1;
			error_d          = 1'b1;
		end

		// Drop all state once the string closes
		if (emit && res.string_done) begin
			partial_d  = '0;
			expected_d = LEN_NONE;
			seen_d     = 3'd0;
			swallow_d  = 1'b0;
			error_d    = 1'b0;
		end
	end

	assign push = accept & emit;

	// Advance sequence state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q  <= '0;
			expected_q <= LEN_NONE;
			seen_q     <= 3'd0;
			swallow_q  <= 1'b0;
			error_q    <= 1'b0;
		end else if (accept) begin
			partial_q  <= partial_d;
			expected_q <= expected_d;
			seen_q     <= seen_d;
			swallow_q  <= swallow_d;
			error_q    <= error_d;
		end
	end

endmodule

FILE: rtl/usp_out_reg.sv
module usp_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  usp_pkg::result_t res,
	output logic             ready,
	usp_out_if.source        out_ch
);
	import usp_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    load_out;

	// Take new requests while the skid entry is free
	assign ready    = !skid_valid_q;
	assign load_out = !out_valid_q || out_ch.ready;

	// Track occupancy of the output and skid entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q  <= skid_valid_q | push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Move payload: skid drains first, else a new request lands
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.char_word    = out_q.char_word;
	assign out_ch.char_bytes   = out_q.char_bytes;
	assign out_ch.has_char     = out_q.has_char;
	assign out_ch.format_error = out_q.format_error;
	assign out_ch.string_done  = out_q.string_done;

endmodule

FILE: tb/sv/utf8_sequence_packer_unit_tb.sv
`timescale 1ns / 100ps

module utf8_sequence_packer_unit_tb;
	import usp_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} byte_req_t;

	logic clk;
	logic arst_n;

	usp_in_if  in_ch ();
	usp_out_if out_ch ();

	utf8_sequence_packer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Bytes waiting to be driven and characters waiting to come out
	byte_req_t  byte_reqs[$];
	result_t    char_results_due[$];
	logic [7:0] str_buf[$];
	int         bytes_loaded = 0;
	int         bytes_issued = 0;
	int         mismatches = 0;
	logic       byte_taken = 1'b0;
	logic       calm;

	// Predicted packer state
	logic [23:0] seq_bytes = '0;
	logic [2:0]  seq_len = LEN_NONE;
	logic [2:0]  seq_got = LEN_NONE;
	logic        draining = 1'b0;
	logic        str_failed = 1'b0;

	// No idling on either side for a stretch in the middle of the run
	assign calm = (bytes_issued >= 200) && (bytes_issued < 300);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic void clear_string();
		seq_bytes = '0;
		seq_len = LEN_NONE;
		seq_got = LEN_NONE;
		draining = 1'b0;
		str_failed = 1'b0;
	endfunction

	// Abort the string: error result, then drop bytes up to the last one
	function automatic bit reject_string(input logic last, output result_t r);
		r = '0;
		r.format_error = 1'b1;
		r.string_done = last;
		seq_bytes = '0;
		seq_len = LEN_NONE;
		seq_got = LEN_NONE;
		draining = 1'b1;
		str_failed = 1'b1;
		if (last) begin
			clear_string();
		end
		return 1'b1;
	endfunction

	// Advance the predicted state by one byte; return 1 when a result is due
	function automatic bit pack_byte(input logic [7:0] b, input logic last, output result_t r);
		logic [31:0] word;
		r = '0;
		if (draining) begin
			if (!last) begin
				return 1'b0;
			end
			r.format_error = str_failed;
			r.string_done = 1'b1;
			clear_string();
			return 1'b1;
		end
		if (seq_len == LEN_NONE) begin
			// terminator with nothing open
			if (b == 8'h00) begin
				if (last) begin
					r.string_done = 1'b1;
					clear_string();
					return 1'b1;
				end
				draining = 1'b1;
				return 1'b0;
			end
			if ((b & ASCII_MASK) == 8'h00) begin
				r.char_word = {24'd0, b};
				r.char_bytes = LEN_ONE;
				r.has_char = 1'b1;
				r.string_done = last;
				if (last) begin
					clear_string();
				end
				return 1'b1;
			end
			if ((b & LEAD2_MASK) == LEAD2_PAT) begin
				seq_len = LEN_TWO;
			end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
				seq_len = LEN_THREE;
			end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
				seq_len = LEN_FOUR;
			end else begin
				return reject_string(last, r);
			end
			// lead byte on the final position cuts the sequence off
			if (last) begin
				return reject_string(1'b1, r);
			end
			seq_bytes = {16'd0, b};
			seq_got = LEN_ONE;
			return 1'b0;
		end
		if ((b & CONT_MASK) != CONT_PAT) begin
			return reject_string(last, r);
		end
		word = {8'd0, seq_bytes} | ({24'd0, b} << (8 * seq_got));
		seq_bytes = word[23:0];
		seq_got = seq_got + 3'd1;
		if (seq_got == seq_len) begin
			r.char_word = word;
			r.char_bytes = seq_got;
			r.has_char = 1'b1;
			r.string_done = last;
			seq_bytes = '0;
			seq_len = LEN_NONE;
			seq_got = LEN_NONE;
			if (last) begin
				clear_string();
			end
			return 1'b1;
		end
		if (last) begin
			return reject_string(1'b1, r);
		end
		return 1'b0;
	endfunction

	// Append one well-formed character of the given length
	task automatic add_char(input logic [2:0] len);
		case (len)
			LEN_ONE: begin
				str_buf.push_back(($urandom_range(15) == 0) ? 8'h00 : 8'($urandom_range(1, 127)));
			end
			LEN_TWO: begin
				str_buf.push_back(LEAD2_PAT | (8'($urandom) & ~LEAD2_MASK));
			end
			LEN_THREE: begin
				str_buf.push_back(LEAD3_PAT | (8'($urandom) & ~LEAD3_MASK));
			end
			default: begin
				str_buf.push_back(LEAD4_PAT | (8'($urandom) & ~LEAD4_MASK));
			end
		endcase
		repeat (int'(len) - 1) begin
			str_buf.push_back(CONT_PAT | (8'($urandom) & ~CONT_MASK));
		end
	endtask

	// Queue the buffered string, flagging its last byte
	task automatic close_string();
		foreach (str_buf[i]) begin
			byte_reqs.push_back('{data: str_buf[i], last: (i == str_buf.size() - 1)});
			bytes_loaded++;
		end
		str_buf.delete();
	endtask

	// Drive byte requests and result ready at the falling edge
	always @(negedge clk) begin
		byte_req_t next_req;
		if (arst_n && (!in_ch.valid || byte_taken)) begin
			if (byte_reqs.size() != 0 && (calm || $urandom_range(99) >= 38)) begin
				next_req = byte_reqs.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.data_byte <= next_req.data;
				in_ch.end_of_string <= next_req.last;
				bytes_issued++;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
		out_ch.ready <= calm || ($urandom_range(99) >= 38);
	end

	// Predict on each accepted byte, check each accepted result
	always @(posedge clk) begin
		result_t fresh;
		result_t seen;
		result_t want;
		byte_taken <= arst_n && (in_ch.valid === 1'b1) && (in_ch.ready === 1'b1);
		if (arst_n && in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
			if (pack_byte(in_ch.data_byte, in_ch.end_of_string, fresh)) begin
				char_results_due.push_back(fresh);
			end
		end
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			seen = {out_ch.char_word, out_ch.char_bytes, out_ch.has_char,
				out_ch.format_error, out_ch.string_done};
			if (char_results_due.size() == 0) begin
				report_mismatch($sformatf("result with none due: word %h bytes %0d", seen.char_word,
					seen.char_bytes));
			end else begin
				want = char_results_due.pop_front();
				if (seen !== want) begin
					report_mismatch($sformatf(
						"word %h/%h bytes %0d/%0d char %b/%b err %b/%b done %b/%b (got/want)",
						seen.char_word, want.char_word, seen.char_bytes, want.char_bytes,
						seen.has_char, want.has_char, seen.format_error, want.format_error,
						seen.string_done, want.string_done));
				end
			end
		end
	end

	initial begin
		int kind;
		in_ch.valid = 1'b0;
		in_ch.data_byte = 8'h00;
		in_ch.end_of_string = 1'b0;
		out_ch.ready = 1'b0;
		arst_n = 1'b0;

		// Two ASCII bytes, then every sequence length with a 4-byte final character
		str_buf = '{8'h41, 8'h7F};
		close_string();
		str_buf = '{8'hC2, 8'h80, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80,
			8'hF7, 8'hBF, 8'hBF, 8'hBF};
		close_string();
		// stray continuation, swallowed bytes, end result with error
		str_buf = '{8'h80, 8'h41, 8'h42};
		close_string();
		// out-of-range lead as the last byte, then mid-string followed by terminator
		str_buf = '{8'hF8};
		close_string();
		str_buf = '{8'hFF, 8'h00};
		close_string();
		// terminator mid-string, lone terminator
		str_buf = '{8'h41, 8'h00, 8'h41, 8'h00};
		close_string();
		str_buf = '{8'h00};
		close_string();
		// cut-off sequences: final lead, final short continuation
		str_buf = '{8'hC3};
		close_string();
		str_buf = '{8'hE0, 8'hA0};
		close_string();
		// non-continuation and zero inside an open sequence
		str_buf = '{8'hE1, 8'h41, 8'h80};
		close_string();
		str_buf = '{8'hC2, 8'h00};
		close_string();

		// Mostly well-formed strings, some corrupted, cut off or pure noise
		while (bytes_loaded < 530) begin
			kind = $urandom_range(9);
			if (kind == 9) begin
				repeat ($urandom_range(1, 10)) begin
					str_buf.push_back(8'($urandom));
				end
			end else begin
				repeat ($urandom_range(1, 8)) begin
					add_char(3'($urandom_range(1, 4)));
				end
				if (kind == 7) begin
					str_buf[$urandom_range(str_buf.size() - 1)] = 8'($urandom);
				end else if (kind == 8) begin
					add_char(3'($urandom_range(2, 4)));
					void'(str_buf.pop_back());
				end
			end
			close_string();
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for the last byte to go in, then for its results to drain
		do begin
			@(posedge clk);
		end while (byte_reqs.size() != 0 || (in_ch.valid && !in_ch.ready));
		repeat (2) @(posedge clk);
		while (char_results_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);

		if (char_results_due.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", char_results_due.size()));
		end
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/usp_pkg.sv
rtl/usp_if.sv
rtl/usp_core.sv
rtl/usp_out_reg.sv
rtl/utf8_sequence_packer_unit.sv
tb/sv/utf8_sequence_packer_unit_tb.sv
